// ----- hw/rtl/sgr_pkg.sv -----
// Swipe gesture recognizer: shared types and constants.
// Used by sgr_eval and swipe_gesture_recognizer_top; depends on nothing.

package sgr_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Configuration register widths and port layout
  localparam int DIST_BITS      = 16;
  localparam int SPEED_BITS     = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_SPEED    = 2'd1;

  // Speed check scale: ms to s (1000) times the 8 fraction bits of min_speed (256)
  localparam int SPEED_SCALE = 256000;
  localparam int SCALE_BITS  = 18;

  // Event kinds
  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  // Recognizer modes
  typedef enum logic [1:0] {
    MODE_WAIT    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_SWIPE   = 2'd2,
    MODE_PASS    = 2'd3
  } mode_t;

  // Direction set by the first two points
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_t;

  // Result verdicts
  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_LEFT   = 2'd1,
    VERDICT_RIGHT  = 2'd2,
    VERDICT_REVERT = 2'd3
  } verdict_t;

endpackage

// ----- hw/rtl/sgr_eval.sv -----
// Swipe gesture recognizer: verdict logic for an evaluate tick.
// Pure combinational; depends on sgr_pkg.

module sgr_eval #(
  parameter int COORD_BITS = sgr_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = sgr_pkg::TIME_BITS_DEF
) (
  input  logic [1:0]                      point_count,
  input  logic                            reversed_flag,
  input  logic signed [COORD_BITS-1:0]    first_x,
  input  logic signed [COORD_BITS-1:0]    previous_x,
  input  logic signed [COORD_BITS-1:0]    lowest_y,
  input  logic signed [COORD_BITS-1:0]    highest_y,
  input  logic [TIME_BITS-1:0]            press_time,
  input  logic [TIME_BITS-1:0]            now,
  input  logic [sgr_pkg::DIST_BITS-1:0]   min_distance,
  input  logic [sgr_pkg::SPEED_BITS-1:0]  min_speed,
  output sgr_pkg::verdict_t               verdict
);

  // Elapsed time beyond this many bits always fails the speed check unless min_speed is zero
  localparam int SCALED_BITS = COORD_BITS + sgr_pkg::SCALE_BITS;
  localparam int ELAPSED_BITS = (TIME_BITS < SCALED_BITS) ? TIME_BITS : SCALED_BITS;
  localparam int PROD_BITS = sgr_pkg::SPEED_BITS + ELAPSED_BITS;
  localparam int CMP_BITS = (PROD_BITS > SCALED_BITS) ? PROD_BITS : SCALED_BITS;
  localparam int DIST_CMP_BITS =
    (COORD_BITS > sgr_pkg::DIST_BITS) ? COORD_BITS : sgr_pkg::DIST_BITS;

  logic signed [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]          dx_mag;
  logic [COORD_BITS-1:0]        adx;
  logic [COORD_BITS:0]          dy_full;
  logic [COORD_BITS-1:0]        dy;
  logic [COORD_BITS+1:0]        adx_x2;
  logic [COORD_BITS+1:0]        dy_x3;
  logic                         steep;
  logic [TIME_BITS-1:0]         elapsed;
  logic [ELAPSED_BITS-1:0]      elapsed_sat;
  logic [SCALED_BITS-1:0]       scaled;
  logic [PROD_BITS-1:0]         speed_prod;
  logic                         slow;
  logic                         far_enough;

  // Horizontal travel and vertical spread
  assign dx      = $signed({previous_x[COORD_BITS-1], previous_x})
                 - $signed({first_x[COORD_BITS-1], first_x});
  assign dx_mag  = dx[COORD_BITS] ? -dx : dx;
  assign adx     = dx_mag[COORD_BITS-1:0];
  assign dy_full = $signed({highest_y[COORD_BITS-1], highest_y})
                 - $signed({lowest_y[COORD_BITS-1], lowest_y});
  assign dy      = dy_full[COORD_BITS-1:0];

  // Angle limit: 2*|dx| < 3*|dy|
  assign adx_x2 = {1'b0, adx, 1'b0};
  assign dy_x3  = {2'b00, dy} + {1'b0, dy, 1'b0};
  assign steep  = adx_x2 < dy_x3;

  // Elapsed time, clamped so the product stays narrow
  assign elapsed = now - press_time;
  generate
    if (TIME_BITS > ELAPSED_BITS) begin : g_clamp
      assign elapsed_sat = (|elapsed[TIME_BITS-1:ELAPSED_BITS])
                         ? {ELAPSED_BITS{1'b1}} : elapsed[ELAPSED_BITS-1:0];
    end else begin : g_noclamp
      assign elapsed_sat = elapsed[ELAPSED_BITS-1:0];
    end
  endgenerate

  // Too slow when min_speed * elapsed > |dx| * 256000
  assign scaled     = SCALED_BITS'({{sgr_pkg::SCALE_BITS{1'b0}}, adx}
                    * SCALED_BITS'(sgr_pkg::SPEED_SCALE));
  assign speed_prod = {{ELAPSED_BITS{1'b0}}, min_speed}
                    * {{sgr_pkg::SPEED_BITS{1'b0}}, elapsed_sat};
  assign slow       = CMP_BITS'(speed_prod) > CMP_BITS'(scaled);

  assign far_enough = DIST_CMP_BITS'(adx) >= DIST_CMP_BITS'(min_distance);

  // Checks in order of precedence
  always_comb begin
    priority if (point_count < 2'd2 || reversed_flag || steep || slow) begin
      verdict = sgr_pkg::VERDICT_REVERT;
    end else if (far_enough) begin
      verdict = dx[COORD_BITS] ? sgr_pkg::VERDICT_LEFT : sgr_pkg::VERDICT_RIGHT;
    end else begin
      verdict = sgr_pkg::VERDICT_NONE;
    end
  end

endmodule

// ----- hw/rtl/swipe_gesture_recognizer_top.sv -----
// Swipe gesture recognizer top level: event pipeline, running path state, result beat.
// Depends on sgr_pkg and sgr_eval.
//
// Usage:
//  - Input channel (in_valid/in_stall): one beat per touch event or evaluate tick,
//    carrying command, pos_x, pos_y and time_ms.
//  - Output channel (out_valid/out_stall): exactly one beat per input beat, in order,
//    with consumed and verdict.
//  - Config port: cfg_write with cfg_index 0 (min_distance) or 1 (min_speed);
//    other indexes are dropped. Write only while no beat is in flight.
//  - Each beat passes one input register, then the combinational mode and running-value
//    update plus tick evaluation, ending in the result register.
//  - Throughput is one beat per cycle while the receiver does not stall; the tick path
//    (one 24-bit by elapsed-time multiply and compare) sets the cycle time.
//  - When the receiver stalls, the result register holds its beat, the input
//    register still fills, and in_stall rises only once both are occupied.
//  - Reset clears both configuration registers to zero, returns to waiting for a
//    press and empties the pipeline; no clearing pass is needed.

module swipe_gesture_recognizer_top #(
  parameter int COORD_BITS = sgr_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = sgr_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // event channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic signed [COORD_BITS-1:0]        pos_x,
  input  logic signed [COORD_BITS-1:0]        pos_y,
  input  logic [TIME_BITS-1:0]                time_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                consumed,
  output logic [1:0]                          verdict,
  // configuration
  input  logic                                cfg_write,
  input  logic [sgr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sgr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // Configuration registers
  logic [sgr_pkg::DIST_BITS-1:0]  min_distance;
  logic [sgr_pkg::SPEED_BITS-1:0] min_speed;

  // Input register
  logic                           s1_valid;
  sgr_pkg::cmd_t                  s1_command;
  logic signed [COORD_BITS-1:0]   s1_x;
  logic signed [COORD_BITS-1:0]   s1_y;
  logic [TIME_BITS-1:0]           s1_time;
  logic                           in_fire;
  logic                           s1_fire;

  // Running path state
  sgr_pkg::mode_t                 mode, mode_next;
  logic [1:0]                     point_count, point_count_next;
  logic signed [COORD_BITS-1:0]   first_x, first_x_next;
  logic signed [COORD_BITS-1:0]   previous_x, previous_x_next;
  sgr_pkg::dir_t                  initial_direction, initial_direction_next;
  logic                           reversed_flag, reversed_flag_next;
  logic signed [COORD_BITS-1:0]   lowest_y, lowest_y_next;
  logic signed [COORD_BITS-1:0]   highest_y, highest_y_next;
  logic [TIME_BITS-1:0]           press_time, press_time_next;

  // Result register
  logic                           res_consumed, res_consumed_next;
  sgr_pkg::verdict_t              res_verdict, res_verdict_next;
  sgr_pkg::verdict_t              tick_verdict;

  // Handshakes: stage 1 moves on when the result register is free or draining
  assign s1_fire  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= '0;
      min_speed    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == sgr_pkg::REG_MIN_DISTANCE) begin
        min_distance <= cfg_data[sgr_pkg::DIST_BITS-1:0];
      end else if (cfg_index == sgr_pkg::REG_MIN_SPEED) begin
        min_speed <= cfg_data[sgr_pkg::SPEED_BITS-1:0];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_command <= sgr_pkg::cmd_t'(command);
      s1_x       <= pos_x;
      s1_y       <= pos_y;
      s1_time    <= time_ms;
    end
  end

  // Tick verdict from the current running values
  sgr_eval #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_eval (
    .point_count   (point_count),
    .reversed_flag (reversed_flag),
    .first_x       (first_x),
    .previous_x    (previous_x),
    .lowest_y      (lowest_y),
    .highest_y     (highest_y),
    .press_time    (press_time),
    .now           (s1_time),
    .min_distance  (min_distance),
    .min_speed     (min_speed),
    .verdict       (tick_verdict)
  );

  // Mode and running-value update for the beat in stage 1
  always_comb begin
    mode_next              = mode;
    point_count_next       = point_count;
    first_x_next           = first_x;
    previous_x_next        = previous_x;
    initial_direction_next = initial_direction;
    reversed_flag_next     = reversed_flag;
    lowest_y_next          = lowest_y;
    highest_y_next         = highest_y;
    press_time_next        = press_time;
    res_consumed_next      = 1'b0;
    res_verdict_next       = sgr_pkg::VERDICT_NONE;

    unique case (s1_command)
      sgr_pkg::CMD_PRESS: begin
        if (mode == sgr_pkg::MODE_SWIPE) begin
          res_consumed_next = 1'b1;
        end else if (mode == sgr_pkg::MODE_WAIT) begin
          mode_next              = sgr_pkg::MODE_COLLECT;
          point_count_next       = 2'd1;
          first_x_next           = s1_x;
          previous_x_next        = s1_x;
          initial_direction_next = sgr_pkg::DIR_NONE;
          reversed_flag_next     = 1'b0;
          lowest_y_next          = s1_y;
          highest_y_next         = s1_y;
          press_time_next        = s1_time;
          res_consumed_next      = 1'b1;
        end
      end
      sgr_pkg::CMD_MOVE: begin
        if (mode == sgr_pkg::MODE_SWIPE) begin
          res_consumed_next = 1'b1;
        end else if (mode == sgr_pkg::MODE_COLLECT) begin
          // second point sets the direction, later points watch for a reversal
          if (point_count <= 2'd1) begin
            if (s1_x > first_x) begin
              initial_direction_next = sgr_pkg::DIR_RIGHT;
            end else if (s1_x < first_x) begin
              initial_direction_next = sgr_pkg::DIR_LEFT;
            end else begin
              initial_direction_next = sgr_pkg::DIR_NONE;
            end
          end else begin
            if ((initial_direction == sgr_pkg::DIR_RIGHT && s1_x < previous_x) ||
                (initial_direction == sgr_pkg::DIR_LEFT && s1_x > previous_x)) begin
              reversed_flag_next = 1'b1;
            end
          end
          if (point_count < 2'd3) begin
            point_count_next = point_count + 2'd1;
          end
          previous_x_next = s1_x;
          if (s1_y < lowest_y) begin
            lowest_y_next = s1_y;
          end
          if (s1_y > highest_y) begin
            highest_y_next = s1_y;
          end
          res_consumed_next = 1'b1;
        end
      end
      sgr_pkg::CMD_RELEASE: begin
        if (mode == sgr_pkg::MODE_SWIPE) begin
          res_consumed_next = 1'b1;
        end else if (mode == sgr_pkg::MODE_COLLECT) begin
          res_verdict_next = sgr_pkg::VERDICT_REVERT;
        end
        mode_next = sgr_pkg::MODE_WAIT;
      end
      sgr_pkg::CMD_TICK: begin
        if (mode == sgr_pkg::MODE_COLLECT) begin
          res_verdict_next = tick_verdict;
          if (tick_verdict == sgr_pkg::VERDICT_REVERT) begin
            mode_next = sgr_pkg::MODE_PASS;
          end else if (tick_verdict != sgr_pkg::VERDICT_NONE) begin
            mode_next = sgr_pkg::MODE_SWIPE;
          end
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= sgr_pkg::MODE_WAIT;
      point_count       <= '0;
      first_x           <= '0;
      previous_x        <= '0;
      initial_direction <= sgr_pkg::DIR_NONE;
      reversed_flag     <= 1'b0;
      lowest_y          <= '0;
      highest_y         <= '0;
      press_time        <= '0;
    end else if (s1_fire) begin
      mode              <= mode_next;
      point_count       <= point_count_next;
      first_x           <= first_x_next;
      previous_x        <= previous_x_next;
      initial_direction <= initial_direction_next;
      reversed_flag     <= reversed_flag_next;
      lowest_y          <= lowest_y_next;
      highest_y         <= highest_y_next;
      press_time        <= press_time_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_consumed <= res_consumed_next;
      res_verdict  <= res_verdict_next;
    end
  end

  assign consumed = res_consumed;
  assign verdict  = res_verdict;

endmodule
